>>> sv/banked_memory_access_router_unit_macros.svh
// Assertion macros shared by the router RTL.
`ifndef BANKED_MEMORY_ACCESS_ROUTER_UNIT_MACROS_SVH
`define BANKED_MEMORY_ACCESS_ROUTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("router assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BMAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("router assertion failed");

`endif

>>> sv/bmar_pkg.sv
`timescale 1ns / 1ps

package bmar_pkg;

  localparam int BOOT_ROM_BYTES_DEF = 256;

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int PA_W        = 22;
  localparam int BANK_CNT_W  = 9;
  localparam int RAM_SIZE_W  = 18;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_INDEX_W = 1;

  localparam logic [BANK_CNT_W-1:0] ROM_BANK_COUNT_RST = 9'd2;
  localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RST       = 18'd0;

  localparam logic [ADDR_W-1:0] ADDR_BOOT_OFF = 16'hFF50;
  localparam logic [ADDR_W-1:0] ADDR_OAM_LO   = 16'hFE00;
  localparam logic [ADDR_W-1:0] ADDR_OAM_HI   = 16'hFE9F;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_BOOT = 3'd1,
    TGT_ROM  = 3'd2,
    TGT_RAM  = 3'd3,
    TGT_INT  = 3'd4
  } target_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROM_BANK_COUNT = 1'b0,
    CFG_RAM_SIZE       = 1'b1
  } cfg_index_t;

  // Controller register selected by address bits 14:13 of a write below 0x8000.
  typedef enum logic [1:0] {
    CREG_RAM_ENABLE = 2'd0,
    CREG_ROM_LOW    = 2'd1,
    CREG_BANK_HIGH  = 2'd2,
    CREG_MODE       = 2'd3
  } ctrl_reg_t;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_write_data;
    logic              video_ram_open;
    logic              sprite_ram_open;
  } item_t;

  typedef struct packed {
    target_t           target;
    logic [PA_W-1:0]   physical_address;
    logic              store_write;
    logic [DATA_W-1:0] store_data;
    logic              bound_error;
    logic              boot_retired;
  } result_t;

  typedef struct packed {
    logic [7:0] rom_bank;
    logic [7:0] ram_bank;
    logic       ram_access_on;
    logic       ram_banking;
    logic       boot_active;
  } bank_state_t;

  localparam bank_state_t BANK_STATE_RST = '{
    rom_bank:      8'd1,
    ram_bank:      8'd0,
    ram_access_on: 1'b0,
    ram_banking:   1'b0,
    boot_active:   1'b1
  };

endpackage

>>> sv/bmar_route.sv
`timescale 1ns / 1ps

module bmar_route #(
  parameter int BOOT_ROM_BYTES = bmar_pkg::BOOT_ROM_BYTES_DEF
) (
  input  bmar_pkg::item_t                         item,
  input  bmar_pkg::bank_state_t                   state,
  input  logic [bmar_pkg::BANK_CNT_W-1:0]         rom_bank_count,
  input  logic [bmar_pkg::RAM_SIZE_W-1:0]         ram_size_bytes,
  output bmar_pkg::result_t                       result,
  output bmar_pkg::bank_state_t                   state_nxt
);
  import bmar_pkg::*;

  logic [ADDR_W-1:0] a;
  logic              in_vram;
  logic              in_oam;
  logic              in_ram;
  logic              locked;
  logic              boot_hit;
  logic [PA_W-1:0]   rom_pa;
  logic [PA_W-1:0]   ram_pa;
  logic              rom_berr;
  logic              ram_berr;
  logic [4:0]        rom_low;
  ctrl_reg_t         creg;

  assign a        = item.bus_address;
  assign in_vram  = (a[15:13] == 3'b100);
  assign in_ram   = (a[15:13] == 3'b101);
  assign in_oam   = (a >= ADDR_OAM_LO) && (a <= ADDR_OAM_HI);
  assign locked   = (in_vram && !item.video_ram_open) || (in_oam && !item.sprite_ram_open);
  assign boot_hit = state.boot_active && (32'(a) < 32'(BOOT_ROM_BYTES));

  // The upper ROM window maps to the selected bank; the lower one is bank zero.
  assign rom_pa   = a[14] ? {state.rom_bank, a[13:0]} : {8'd0, a[13:0]};
  assign rom_berr = {1'b0, rom_pa[21:14]} >= rom_bank_count;
  assign ram_pa   = {1'b0, state.ram_bank, a[12:0]};
  assign ram_berr = ram_pa >= {4'd0, ram_size_bytes};
  assign rom_low  = (item.bus_write_data[4:0] == 5'd0) ? 5'd1 : item.bus_write_data[4:0];
  assign creg     = ctrl_reg_t'(a[14:13]);

  always_comb begin
    result    = '{target: TGT_NONE, default: '0};
    state_nxt = state;
    if (!item.operation) begin
      if (boot_hit) begin
        result.target           = TGT_BOOT;
        result.physical_address = {6'd0, a};
      end else if (locked) begin
        result.target = TGT_NONE;
      end else if (!a[15]) begin
        result.target           = TGT_ROM;
        result.physical_address = rom_pa;
        result.bound_error      = rom_berr;
      end else if (in_ram) begin
        if (state.ram_access_on) begin
          result.target           = TGT_RAM;
          result.physical_address = ram_pa;
          result.bound_error      = ram_berr;
        end
      end else begin
        result.target           = TGT_INT;
        result.physical_address = {6'd0, a};
      end
    end else begin
      if (a == ADDR_BOOT_OFF) begin
        state_nxt.boot_active   = 1'b0;
        result.target           = TGT_INT;
        result.physical_address = {6'd0, a};
        result.store_write      = 1'b1;
        result.store_data       = item.bus_write_data;
        result.boot_retired     = 1'b1;
      end else if (locked) begin
        result.target = TGT_NONE;
      end else if (!a[15]) begin
        case (creg)
          CREG_RAM_ENABLE: begin
            state_nxt.ram_access_on = (item.bus_write_data[3:0] == 4'hA);
          end
          CREG_ROM_LOW: begin
            state_nxt.rom_bank = {state.rom_bank[7:5], rom_low};
          end
          CREG_BANK_HIGH: begin
            if (state.ram_banking) begin
              state_nxt.ram_bank = item.bus_write_data;
            end else begin
              state_nxt.rom_bank = {item.bus_write_data[7:5], state.rom_bank[4:0]};
            end
          end
          CREG_MODE: begin
            state_nxt.ram_banking = item.bus_write_data[0];
          end
          default: begin
            state_nxt = state;
          end
        endcase
      end else if (in_ram) begin
        if (state.ram_access_on) begin
          result.target           = TGT_RAM;
          result.physical_address = ram_pa;
          result.store_write      = 1'b1;
          result.store_data       = item.bus_write_data;
          result.bound_error      = ram_berr;
        end
      end else begin
        result.target           = TGT_INT;
        result.physical_address = {6'd0, a};
        result.store_write      = 1'b1;
        result.store_data       = item.bus_write_data;
      end
    end
  end

endmodule

>>> sv/bmar_state_regs.sv
`timescale 1ns / 1ps

`include "banked_memory_access_router_unit_macros.svh"

module bmar_state_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmar_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bmar_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                advance,
  input  bmar_pkg::bank_state_t               state_nxt,
  output bmar_pkg::bank_state_t               state,
  output logic [bmar_pkg::BANK_CNT_W-1:0]     rom_bank_count,
  output logic [bmar_pkg::RAM_SIZE_W-1:0]     ram_size_bytes
);
  import bmar_pkg::*;

  bank_state_t             state_r;
  logic [BANK_CNT_W-1:0]   rom_bank_count_r;
  logic [RAM_SIZE_W-1:0]   ram_size_bytes_r;

  // Controller state moves only when a request leaves the input stage, so
  // register writes take effect in request order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BANK_STATE_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_count_r <= ROM_BANK_COUNT_RST;
      ram_size_bytes_r <= RAM_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROM_BANK_COUNT: begin
          rom_bank_count_r <= cfg_data[BANK_CNT_W-1:0];
        end
        CFG_RAM_SIZE: begin
          ram_size_bytes_r <= cfg_data[RAM_SIZE_W-1:0];
        end
        default: begin
          rom_bank_count_r <= rom_bank_count_r;
        end
      endcase
    end
  end

  assign state          = state_r;
  assign rom_bank_count = rom_bank_count_r;
  assign ram_size_bytes = ram_size_bytes_r;

  `BMAR_ASSERT_NEXT(a_boot_stays_retired, clk, rst_n, !state_r.boot_active, !state_r.boot_active)
  `BMAR_ASSERT_IMPL(a_rom_low_nonzero, clk, rst_n, 1'b1, state_r.rom_bank[4:0] != 5'd0)
  `BMAR_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !advance, $stable(state_r))

endmodule

>>> sv/banked_memory_access_router_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | operation, bus address, write byte, open flags
// out_     | output    | out_valid/out_stall| target, physical address, write, data, flags
// cfg_     | input     | cfg_we             | cfg_index, cfg_data (ROM bank count, RAM size)
//
// Each request is held in the input register and is routed into the output
// register as it advances: one request per cycle while out_stall does not hold the output register.
// Bank controller state is updated as a request moves into the output register.
// rst_n is synchronous and clears the valid flags, bank state and config registers.
// out_stall holds the output register; in_stall rises only when the input
// register is full and cannot move forward.
module banked_memory_access_router_unit #(
  parameter int BOOT_ROM_BYTES = bmar_pkg::BOOT_ROM_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [15:0]                         in_bus_address,
  input  logic [7:0]                          in_bus_write_data,
  input  logic                                in_video_ram_open,
  input  logic                                in_sprite_ram_open,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_target,
  output logic [21:0]                         out_physical_address,
  output logic                                out_store_write,
  output logic [7:0]                          out_store_data,
  output logic                                out_bound_error,
  output logic                                out_boot_retired,
  input  logic                                cfg_we,
  input  logic [bmar_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bmar_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bmar_pkg::*;

  `include "banked_memory_access_router_unit_macros.svh"

  item_t                 item_r;
  logic                  s1_valid_r;
  result_t               result_r;
  logic                  out_valid_r;
  logic                  advance;
  logic                  in_accept;
  result_t               result_nxt;
  bank_state_t           state;
  bank_state_t           state_nxt;
  logic [BANK_CNT_W-1:0] rom_bank_count;
  logic [RAM_SIZE_W-1:0] ram_size_bytes;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= '{
        operation:       in_operation,
        bus_address:     in_bus_address,
        bus_write_data:  in_bus_write_data,
        video_ram_open:  in_video_ram_open,
        sprite_ram_open: in_sprite_ram_open
      };
    end
  end

  bmar_route #(
    .BOOT_ROM_BYTES(BOOT_ROM_BYTES)
  ) u_route (
    .item           (item_r),
    .state          (state),
    .rom_bank_count (rom_bank_count),
    .ram_size_bytes (ram_size_bytes),
    .result         (result_nxt),
    .state_nxt      (state_nxt)
  );

  bmar_state_regs u_state_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .advance        (advance),
    .state_nxt      (state_nxt),
    .state          (state),
    .rom_bank_count (rom_bank_count),
    .ram_size_bytes (ram_size_bytes)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_target           = result_r.target;
  assign out_physical_address = result_r.physical_address;
  assign out_store_write      = result_r.store_write;
  assign out_store_data       = result_r.store_data;
  assign out_bound_error      = result_r.bound_error;
  assign out_boot_retired     = result_r.boot_retired;

  `BMAR_ASSERT_IMPL(a_none_is_quiet, clk, rst_n, out_valid_r && (result_r.target == TGT_NONE), (result_r.physical_address == '0) && !result_r.store_write && !result_r.bound_error)
  `BMAR_ASSERT_IMPL(a_retire_is_write, clk, rst_n, out_valid_r && result_r.boot_retired, (result_r.target == TGT_INT) && result_r.store_write)
  `BMAR_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r && out_stall)

endmodule

>>> test/tb_banked_memory_access_router_unit.sv
`timescale 1ns / 1ps

module tb_banked_memory_access_router_unit;
  import bmar_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [15:0] ROM_LOW_END  = 16'h3FFF;
  localparam logic [15:0] ROM_BANK_LO  = 16'h4000;
  localparam logic [15:0] ROM_END      = 16'h7FFF;
  localparam logic [15:0] VRAM_LO      = 16'h8000;
  localparam logic [15:0] VRAM_HI      = 16'h9FFF;
  localparam logic [15:0] CRAM_LO      = 16'hA000;
  localparam logic [15:0] CRAM_HI      = 16'hBFFF;
  localparam int unsigned ROM_BANK_SZ  = 32'h4000;
  localparam int unsigned RAM_BANK_SZ  = 32'h2000;
  localparam int unsigned RAM_MAX      = 131072;
  localparam int          STALL_PCT    = 19;
  localparam int          WATCHDOG_MAX = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic [15:0] in_bus_address;
  logic [7:0]  in_bus_write_data;
  logic        in_video_ram_open;
  logic        in_sprite_ram_open;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_target;
  logic [21:0] out_physical_address;
  logic        out_store_write;
  logic [7:0]  out_store_data;
  logic        out_bound_error;
  logic        out_boot_retired;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Model of the bank controller and of the size registers.
  bank_state_t mbc;
  int unsigned rom_banks_cfg;
  int unsigned ram_bytes_cfg;

  result_t routed_q[$];
  int      mismatches;
  int      idle_cycles;
  logic    steady;

  banked_memory_access_router_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_operation         (in_operation),
    .in_bus_address       (in_bus_address),
    .in_bus_write_data    (in_bus_write_data),
    .in_video_ram_open    (in_video_ram_open),
    .in_sprite_ram_open   (in_sprite_ram_open),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_target           (out_target),
    .out_physical_address (out_physical_address),
    .out_store_write      (out_store_write),
    .out_store_data       (out_store_data),
    .out_bound_error      (out_bound_error),
    .out_boot_retired     (out_boot_retired),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Routes one bus request and advances the bank controller state.
  function automatic result_t route_access(input item_t rq);
    result_t     r;
    logic [15:0] a;
    logic [7:0]  d;
    logic [4:0]  lo;
    logic        locked;
    logic        in_cram;
    int unsigned pa;
    r = '0;
    r.target = TGT_NONE;
    a = rq.bus_address;
    d = rq.bus_write_data;
    locked = (a >= VRAM_LO && a <= VRAM_HI && !rq.video_ram_open) ||
             (a >= ADDR_OAM_LO && a <= ADDR_OAM_HI && !rq.sprite_ram_open);
    in_cram = a >= CRAM_LO && a <= CRAM_HI;
    pa = (32'(a) - 32'(CRAM_LO)) + 32'(mbc.ram_bank) * RAM_BANK_SZ;
    if (rq.operation == OP_READ) begin
      if (mbc.boot_active && a < BOOT_ROM_BYTES_DEF) begin
        r.target = TGT_BOOT;
        r.physical_address = {6'd0, a};
      end else if (locked) begin
        r.target = TGT_NONE;
      end else if (a <= ROM_END) begin
        pa = (a <= ROM_LOW_END) ? 32'(a)
             : (32'(a) - 32'(ROM_BANK_LO)) + 32'(mbc.rom_bank) * ROM_BANK_SZ;
        r.target = TGT_ROM;
        r.physical_address = pa[21:0];
        r.bound_error = pa >= rom_banks_cfg * ROM_BANK_SZ;
      end else if (in_cram) begin
        if (mbc.ram_access_on) begin
          r.target = TGT_RAM;
          r.physical_address = pa[21:0];
          r.bound_error = pa >= ram_bytes_cfg;
        end
      end else begin
        r.target = TGT_INT;
        r.physical_address = {6'd0, a};
      end
      return r;
    end
    if (a == ADDR_BOOT_OFF) begin
      mbc.boot_active = 1'b0;
      r.target = TGT_INT;
      r.physical_address = {6'd0, a};
      r.store_write = 1'b1;
      r.store_data = d;
      r.boot_retired = 1'b1;
    end else if (locked) begin
      r.target = TGT_NONE;
    end else if (a <= ROM_END) begin
      case (ctrl_reg_t'(a[14:13]))
        CREG_RAM_ENABLE: mbc.ram_access_on = (d[3:0] == 4'hA);
        CREG_ROM_LOW: begin
          lo = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
          mbc.rom_bank = {mbc.rom_bank[7:5], lo};
        end
        CREG_BANK_HIGH: begin
          if (mbc.ram_banking) mbc.ram_bank = d;
          else mbc.rom_bank = {d[7:5], mbc.rom_bank[4:0]};
        end
        CREG_MODE: mbc.ram_banking = d[0];
        default: ;
      endcase
    end else if (in_cram) begin
      if (mbc.ram_access_on) begin
        r.target = TGT_RAM;
        r.physical_address = pa[21:0];
        r.store_write = 1'b1;
        r.store_data = d;
        r.bound_error = pa >= ram_bytes_cfg;
      end
    end else begin
      r.target = TGT_INT;
      r.physical_address = {6'd0, a};
      r.store_write = 1'b1;
      r.store_data = d;
    end
    return r;
  endfunction

  function automatic item_t bus_access(input logic op, input logic [15:0] addr,
                                       input logic [7:0] data, input logic vopen,
                                       input logic sopen);
    item_t rq;
    rq.operation = op;
    rq.bus_address = addr;
    rq.bus_write_data = data;
    rq.video_ram_open = vopen;
    rq.sprite_ram_open = sopen;
    return rq;
  endfunction

  // Random request, weighted toward the regions where the controller has state.
  function automatic item_t random_access();
    item_t rq;
    int    sel;
    sel = $urandom_range(0, 99);
    rq.operation = 1'($urandom_range(0, 1));
    rq.bus_write_data = 8'($urandom_range(0, 255));
    rq.video_ram_open = ($urandom_range(0, 3) != 0);
    rq.sprite_ram_open = ($urandom_range(0, 3) != 0);
    if (sel < 10) begin
      rq.bus_address = 16'($urandom_range(0, 16'hFFFF));
    end else if (sel < 28) begin
      rq.operation = OP_WRITE;
      rq.bus_address = 16'($urandom_range(0, ROM_END));
      if ($urandom_range(0, 2) == 0) rq.bus_write_data[3:0] = 4'hA;
    end else if (sel < 46) begin
      rq.operation = OP_READ;
      rq.bus_address = 16'($urandom_range(0, ROM_END));
    end else if (sel < 66) begin
      rq.bus_address = 16'($urandom_range(CRAM_LO, CRAM_HI));
    end else if (sel < 75) begin
      rq.bus_address = 16'($urandom_range(VRAM_LO, VRAM_HI));
    end else if (sel < 83) begin
      rq.bus_address = 16'($urandom_range(16'hFDF0, 16'hFEBF));
    end else if (sel < 92) begin
      rq.bus_address = 16'($urandom_range(16'hC000, 16'hFFFF));
    end else if (sel < 94) begin
      rq.bus_address = ADDR_BOOT_OFF;
    end else begin
      rq.bus_address = 16'($urandom_range(16'hFF00, 16'hFFFF));
    end
    return rq;
  endfunction

  task automatic send_access(input item_t rq);
    in_valid <= 1'b1;
    in_operation <= rq.operation;
    in_bus_address <= rq.bus_address;
    in_bus_write_data <= rq.bus_write_data;
    in_video_ram_open <= rq.video_ram_open;
    in_sprite_ram_open <= rq.sprite_ram_open;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    routed_q.push_back(route_access(rq));
    while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (routed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ROM_BANK_COUNT) rom_banks_cfg = value & 32'h1FF;
    else ram_bytes_cfg = value & 32'h3FFFF;
  endtask

  task automatic set_sizes(input int unsigned rom_banks, input int unsigned ram_bytes);
    drain_requests();
    write_cfg(CFG_ROM_BANK_COUNT, rom_banks);
    write_cfg(CFG_RAM_SIZE, ram_bytes);
  endtask

  // Boot ROM overlay: it shadows low reads, not register writes, until 0xFF50 is written.
  task automatic test_boot_overlay();
    send_access(bus_access(OP_READ, 16'h0000, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(OP_READ, 16'h00FF, 8'hFF, 1'b1, 1'b1));
    send_access(bus_access(OP_READ, 16'h0100, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(OP_READ, ROM_END, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(OP_WRITE, 16'h0000, 8'h0A, 1'b1, 1'b1));
    send_access(bus_access(OP_READ, CRAM_LO, 8'h00, 1'b1, 1'b1));
    send_access(bus_access(OP_WRITE, ADDR_BOOT_OFF, 8'hFF, 1'b1, 1'b1));
    send_access(bus_access(OP_READ, 16'h0000, 8'h00, 1'b1, 1'b1));
  endtask

  task automatic test_bank_registers();
    set_sizes(256, RAM_MAX);
    send_access(bus_access(OP_WRITE, 16'h2000, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, ROM_LOW_END, 8'hFF, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, ROM_BANK_LO, 8'hE0, 1'b0, 1'b0));
    send_access(bus_access(OP_READ, ROM_END, 8'h00, 1'b0, 1'b0));
    // Only bit 0 of the mode byte counts.
    send_access(bus_access(OP_WRITE, 16'h6000, 8'hFE, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, ROM_END, 8'h03, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, 16'h5FFF, 8'hFF, 1'b0, 1'b0));
    send_access(bus_access(OP_READ, CRAM_HI, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, CRAM_LO, 8'h5A, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, 16'h1FFF, 8'h1B, 1'b0, 1'b0));
    send_access(bus_access(OP_READ, 16'hA123, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, 16'hB000, 8'hA5, 1'b0, 1'b0));
  endtask

  task automatic test_locked_regions();
    send_access(bus_access(OP_READ, VRAM_LO, 8'h00, 1'b0, 1'b1));
    send_access(bus_access(OP_WRITE, VRAM_HI, 8'h77, 1'b0, 1'b1));
    send_access(bus_access(OP_READ, 16'h9000, 8'h00, 1'b1, 1'b0));
    send_access(bus_access(OP_WRITE, ADDR_OAM_HI, 8'h11, 1'b1, 1'b0));
    send_access(bus_access(OP_READ, ADDR_OAM_LO, 8'h00, 1'b0, 1'b1));
    send_access(bus_access(OP_READ, 16'hFEA0, 8'h00, 1'b0, 1'b0));
    send_access(bus_access(OP_WRITE, 16'hFFFF, 8'hC3, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_access(random_access());
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (routed_q.size() == 0) begin
        $error("result with no request pending: target %0d address %h",
               out_target, out_physical_address);
        mismatches++;
      end else begin
        want = routed_q.pop_front();
        if (out_target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, out_target);
          mismatches++;
        end
        if (out_physical_address !== want.physical_address) begin
          $error("physical_address: expected %h, got %h",
                 want.physical_address, out_physical_address);
          mismatches++;
        end
        if (out_store_write !== want.store_write) begin
          $error("store_write: expected %b, got %b", want.store_write, out_store_write);
          mismatches++;
        end
        if (out_store_data !== want.store_data) begin
          $error("store_data: expected %h, got %h", want.store_data, out_store_data);
          mismatches++;
        end
        if (out_bound_error !== want.bound_error) begin
          $error("bound_error: expected %b, got %b", want.bound_error, out_bound_error);
          mismatches++;
        end
        if (out_boot_retired !== want.boot_retired) begin
          $error("boot_retired: expected %b, got %b", want.boot_retired, out_boot_retired);
          mismatches++;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < STALL_PCT);
  end

  // Ends a hung run: too many cycles in a row with no request or result moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("banked_memory_access_router_unit: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_READ;
    in_bus_address <= '0;
    in_bus_write_data <= '0;
    in_video_ram_open <= 1'b0;
    in_sprite_ram_open <= 1'b0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROM_BANK_COUNT;
    cfg_data <= '0;
    idle_cycles <= 0;
    mismatches = 0;
    steady = 1'b0;
    mbc = BANK_STATE_RST;
    rom_banks_cfg = 32'(ROM_BANK_COUNT_RST);
    ram_bytes_cfg = 32'(RAM_SIZE_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_boot_overlay();
    test_bank_registers();
    test_locked_regions();

    set_sizes(2, 0);
    test_random_traffic(380);
    set_sizes(256, RAM_MAX);
    test_random_traffic(380);
    set_sizes($urandom_range(2, 256), $urandom_range(0, RAM_MAX));
    steady = 1'b1;
    test_random_traffic(380);
    steady = 1'b0;
    set_sizes($urandom_range(2, 256), $urandom_range(0, RAM_MAX));
    test_random_traffic(380);
    set_sizes(64, 8192);
    test_random_traffic(380);

    drain_requests();
    repeat (6) @(posedge clk);
    if (routed_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("banked_memory_access_router_unit: match");
    end else begin
      $display("banked_memory_access_router_unit: mismatch");
    end
    $finish;
  end

endmodule
